/* design/lru_hot_item_tracker_macros.svh */
// Assertion macros for the LRU hot item tracker.
`ifndef LRU_HOT_ITEM_TRACKER_MACROS_SVH
`define LRU_HOT_ITEM_TRACKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LHT_ASSERT_IMP(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
        else $error("lru tracker check failed");
`define LHT_ASSERT_NXT(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
        else $error("lru tracker check failed");
`else
`define LHT_ASSERT_IMP(lbl, ck, rn, a, b)
`define LHT_ASSERT_NXT(lbl, ck, rn, a, b)
`endif
`endif

/* design/lht_pkg.sv */
// Package with types and codes for the LRU hot item tracker.
`timescale 1ns / 1ps
package lht_pkg;
    localparam int DEF_CAPACITY = 32;
    localparam int MAX_RESULTS  = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DUMP   = 2'd1;
    localparam logic [1:0] CMD_DRAIN  = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [2:0] ST_REFRESHED = 3'd0;
    localparam logic [2:0] ST_ALLOCATED = 3'd1;
    localparam logic [2:0] ST_REPLACED  = 3'd2;
    localparam logic [2:0] ST_LISTED    = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] list_id;
        logic [31:0] stripe_id;
        logic [31:0] chunk_id;
        logic [31:0] key_handle;
        logic [7:0]  key_length;
        logic [5:0]  limit;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_list_id;
        logic [31:0] out_stripe_id;
        logic [31:0] out_chunk_id;
        logic [31:0] out_key_handle;
        logic [7:0]  out_key_length;
        logic [5:0]  used_count;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic insert;
        logic list;
        logic done;
        logic clear;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       count_zero;
        logic       list_last;
        logic       out_free;
    } ctl_sts_t;
endpackage

/* design/lru_hot_item_tracker.sv */
// Insert: accepted in idle, result registered in the execute state; next item accepted back in idle.
// Dump and drain: one listed entry per cycle unless the output stalls (rank lookup over all slots).
// Clear: table emptied. Output stalls hold the sequencer; one finished result waits in the register.
// Reset empties the table at once; no clearing pass is needed.
// Top level of the LRU hot item tracker.
`timescale 1ns / 1ps
`include "lru_hot_item_tracker_macros.svh"
module lru_hot_item_tracker
    import lht_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);
    ctl_cmd_t ctl;
    ctl_sts_t sts;

    lht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    lht_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .ctl       (ctl),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `LHT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `LHT_ASSERT_IMP(a_single_result_last, clk, rst_n, out_valid && out_data.status != ST_LISTED, out_data.last)
    `LHT_ASSERT_IMP(a_clear_empties, clk, rst_n, ctl.clear && !ctl.list, !ctl.insert)
endmodule

/* design/lht_ctrl.sv */
// Controller state machine for the LRU hot item tracker.
`timescale 1ns / 1ps
module lht_ctrl
    import lht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  ctl_sts_t sts,
    output ctl_cmd_t ctl
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            default:
            begin
                if (sts.out_free)
                begin
                    unique case (sts.cmd)
                        CMD_INSERT:
                        begin
                            ctl.insert = 1'b1;
                            state_next = S_IDLE;
                        end
                        CMD_CLEAR:
                        begin
                            ctl.clear  = 1'b1;
                            ctl.done   = 1'b1;
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            if (sts.count_zero)
                            begin
                                ctl.done   = 1'b1;
                                ctl.clear  = (sts.cmd == CMD_DRAIN);
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                ctl.list = 1'b1;
                                if (sts.list_last)
                                begin
                                    ctl.clear  = (sts.cmd == CMD_DRAIN);
                                    state_next = S_IDLE;
                                end
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

/* design/lht_datapath.sv */
// Datapath of the LRU hot item tracker: entry table, ranks and result register.
`timescale 1ns / 1ps
module lht_datapath
    import lht_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  ctl_cmd_t  ctl,
    output ctl_sts_t  sts,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > 6) ? CNT_W : 6;

    logic [31:0]      ent_list_reg   [CAPACITY];
    logic [31:0]      ent_stripe_reg [CAPACITY];
    logic [31:0]      ent_chunk_reg  [CAPACITY];
    logic [31:0]      ent_handle_reg [CAPACITY];
    logic [7:0]       ent_len_reg    [CAPACITY];
    logic [CAPACITY-1:0] in_use_reg, in_use_next;
    logic [IDX_W-1:0] rank_reg [CAPACITY];
    logic [IDX_W-1:0] rank_next [CAPACITY];
    logic [CNT_W-1:0] used_reg, used_next;
    in_item_t         req_reg;
    logic [CW-1:0]    pos_reg;
    logic             out_valid_reg;
    out_item_t        out_reg, out_next;

    logic [CAPACITY-1:0] hit, old, sel;
    logic [IDX_W-1:0] hit_idx, free_idx, old_idx, tgt;
    logic             hit_any;
    logic [CNT_W-1:0] bound;
    logic [2:0]       ins_status;
    logic [CW-1:0]    used_ext, lim_ext, cnt;
    logic [CW-1:0]    used_after_ext;
    logic [CW-1:0]    used_next_ext;
    logic [31:0]      sel_list, sel_stripe, sel_chunk, sel_handle;
    logic [7:0]       sel_len;

    assign used_ext      = CW'(used_reg);
    assign lim_ext       = CW'(req_reg.limit);
    assign used_next_ext = CW'(used_next);

    always_comb
    begin
        cnt = used_ext;
        if (lim_ext != '0 && lim_ext < used_ext)
            cnt = lim_ext;
        if (cnt > CW'(MAX_RESULTS))
            cnt = CW'(MAX_RESULTS);
    end

    assign sts.cmd        = req_reg.cmd;
    assign sts.count_zero = (cnt == '0);
    assign sts.list_last  = ((pos_reg + CW'(1)) == cnt);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        old_idx  = '0;
        hit_any  = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            hit[i] = in_use_reg[i] && ent_list_reg[i] == req_reg.list_id
                     && ent_stripe_reg[i] == req_reg.stripe_id
                     && ent_chunk_reg[i] == req_reg.chunk_id;
            old[i] = in_use_reg[i] && (CNT_W'(rank_reg[i]) == used_reg - CNT_W'(1));
            sel[i] = in_use_reg[i] && (CW'(rank_reg[i]) == pos_reg);
            if (hit[i])
            begin
                hit_idx = IDX_W'(i);
                hit_any = 1'b1;
            end
            if (!in_use_reg[i])
                free_idx = IDX_W'(i);
            if (old[i])
                old_idx = IDX_W'(i);
        end
    end

    always_comb
    begin
        sel_list   = '0;
        sel_stripe = '0;
        sel_chunk  = '0;
        sel_handle = '0;
        sel_len    = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (sel[i])
            begin
                sel_list   = sel_list   | ent_list_reg[i];
                sel_stripe = sel_stripe | ent_stripe_reg[i];
                sel_chunk  = sel_chunk  | ent_chunk_reg[i];
                sel_handle = sel_handle | ent_handle_reg[i];
                sel_len    = sel_len    | ent_len_reg[i];
            end
        end
    end

    always_comb
    begin
        in_use_next = in_use_reg;
        used_next   = used_reg;
        for (int i = 0; i < CAPACITY; i++)
            rank_next[i] = rank_reg[i];
        if (hit_any)
        begin
            tgt        = hit_idx;
            ins_status = ST_REFRESHED;
            bound      = CNT_W'(rank_reg[hit_idx]);
        end
        else if (used_reg < CNT_W'(CAPACITY))
        begin
            tgt        = free_idx;
            ins_status = ST_ALLOCATED;
            bound      = used_reg;
        end
        else
        begin
            tgt        = old_idx;
            ins_status = ST_REPLACED;
            bound      = CNT_W'(rank_reg[old_idx]);
        end
        if (ctl.insert)
        begin
            for (int i = 0; i < CAPACITY; i++)
                if (in_use_reg[i] && CNT_W'(rank_reg[i]) < bound)
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
            rank_next[tgt] = '0;
            if (ins_status == ST_ALLOCATED)
            begin
                in_use_next[tgt] = 1'b1;
                used_next        = used_reg + CNT_W'(1);
            end
        end
        if (ctl.clear)
        begin
            in_use_next = '0;
            used_next   = '0;
            for (int i = 0; i < CAPACITY; i++)
                rank_next[i] = '0;
        end
    end

    assign used_after_ext = (req_reg.cmd == CMD_DRAIN) ? '0 : used_ext;

    always_comb
    begin
        out_next = '0;
        if (ctl.insert)
        begin
            out_next.status     = ins_status;
            out_next.used_count = used_next_ext[5:0];
            out_next.last       = 1'b1;
        end
        else if (ctl.list)
        begin
            out_next.status         = ST_LISTED;
            out_next.out_list_id    = sel_list;
            out_next.out_stripe_id  = sel_stripe;
            out_next.out_chunk_id   = sel_chunk;
            out_next.out_key_handle = sel_handle;
            out_next.out_key_length = sel_len;
            out_next.used_count     = used_after_ext[5:0];
            out_next.last           = sts.list_last;
        end
        else
        begin
            out_next.status = ST_DONE;
            out_next.last   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            req_reg <= in_data;
        if (ctl.insert && ins_status != ST_REFRESHED)
        begin
            ent_list_reg[tgt]   <= req_reg.list_id;
            ent_stripe_reg[tgt] <= req_reg.stripe_id;
            ent_chunk_reg[tgt]  <= req_reg.chunk_id;
            ent_handle_reg[tgt] <= req_reg.key_handle;
            ent_len_reg[tgt]    <= req_reg.key_length;
        end
        if (ctl.insert || ctl.list || ctl.done)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            used_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CAPACITY; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            used_reg   <= used_next;
            for (int i = 0; i < CAPACITY; i++)
                rank_reg[i] <= rank_next[i];
            if (ctl.load)
                pos_reg <= '0;
            else if (ctl.list)
                pos_reg <= pos_reg + CW'(1);
            if (ctl.insert || ctl.list || ctl.done)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule
